>>> src/mme_pkg.sv
// Package for the matrix multiply engine: state type, request kind codes,
// register indexes and fixed field widths. No dependencies.
`timescale 1ns / 1ps

package mme_pkg;

    // Fixed field widths.
    localparam int IDX_FIELD_W = 3;
    localparam int ELEM_W      = 16;
    localparam int RES_W       = 32;
    localparam int DIM_W       = 4;

    // Request kinds carried in s_tuser.
    localparam logic [1:0] KIND_LOAD_A  = 2'd0;
    localparam logic [1:0] KIND_LOAD_B  = 2'd1;
    localparam logic [1:0] KIND_COMPUTE = 2'd2;

    // Register indexes (byte address divided by four).
    localparam logic [1:0] REG_ROWS_A    = 2'd0;
    localparam logic [1:0] REG_INNER_DIM = 2'd1;
    localparam logic [1:0] REG_COLS_B    = 2'd2;

    localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

    // Saturation bounds of a signed Q16.16 result.
    localparam logic [RES_W-1:0] RES_MAX = 32'h7FFF_FFFF;
    localparam logic [RES_W-1:0] RES_MIN = 32'h8000_0000;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_WAIT
    } state_t;

endpackage

>>> src/matrix_multiply_engine.sv
// Matrix multiply engine top level: operand stores, sequencer, one shared
// multiply-accumulate and output register. Depends on mme_pkg.
`timescale 1ns / 1ps

// W = A * B on signed Q8.8 elements with saturated signed Q16.16 results.
// A request on the input stream either loads one element of A or B (kind 0
// or 1, addressed by row and column) or starts a compute run (kind 2); kind
// 3 is accepted and dropped, and loads outside MAX_DIM x MAX_DIM are dropped.
// Loads may arrive back to back. A compute run emits rows_a * cols_b
// results in row-major order, the last one with tlast set, and tuser set
// on any result whose sum was clipped. Each result is built from one
// product a cycle out of the single read port of each operand store and
// the one shared 16 x 16 multiplier, followed by the read, multiply and
// accumulate stages draining into the output register. The input stream
// is not ready during a run. A dimension register written as zero counts
// as one, and one above MAX_DIM counts as MAX_DIM. Configuration is
// written over the APB port at byte addresses 0, 4 and 8; the user must
// write it only while no run is in progress, as the block does not check.
// An element must be loaded before a run reads it.
module matrix_multiply_engine
    import mme_pkg::*;
#(
    parameter int MAX_DIM = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    // Input requests.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // row[2:0], col[5:3], value[21:6], zero fill
    input  logic [1:0]  s_tuser,   // kind[1:0]
    // Result stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // out_row[2:0], out_col[5:3], out_value[37:6], zero fill
    output logic [0:0]  m_tuser,   // saturated[0]
    output logic        m_tlast,   // last
    // Configuration.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    // Wide enough for the exact sum of MAX_DIM products.
    localparam int ACC_W  = RES_W + IDX_W + 1;

    // Dimension register value as used by a run.
    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] r);
        logic [DIM_W-1:0] d;
        d = r;
        if (r == '0)
        begin
            d = 4'd1;
        end
        else if (32'(r) > MAX_DIM)
        begin
            d = DIM_W'(MAX_DIM);
        end
        return d;
    endfunction

    // Input field split.
    logic [IDX_FIELD_W-1:0] in_row;
    logic [IDX_FIELD_W-1:0] in_col;
    logic [ELEM_W-1:0]      in_value;
    logic [1:0]             in_kind;

    assign in_row   = s_tdata[2:0];
    assign in_col   = s_tdata[5:3];
    assign in_value = s_tdata[21:6];
    assign in_kind  = s_tuser;

    // Configuration registers.
    logic [DIM_W-1:0] rows_a_reg;
    logic [DIM_W-1:0] inner_dim_reg;
    logic [DIM_W-1:0] cols_b_reg;
    logic             cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_a_reg    <= DIM_RESET;
            inner_dim_reg <= DIM_RESET;
            cols_b_reg    <= DIM_RESET;
        end
        else if (cfg_write)
        begin
            case (paddr[3:2])
                REG_ROWS_A:    rows_a_reg    <= pwdata[DIM_W-1:0];
                REG_INNER_DIM: inner_dim_reg <= pwdata[DIM_W-1:0];
                REG_COLS_B:    cols_b_reg    <= pwdata[DIM_W-1:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_ROWS_A:    prdata = {28'd0, rows_a_reg};
            REG_INNER_DIM: prdata = {28'd0, inner_dim_reg};
            REG_COLS_B:    prdata = {28'd0, cols_b_reg};
            default:       prdata = 32'd0;
        endcase
    end

    // Last index of each loop, as used by the sequencer.
    logic [DIM_W-1:0] m_last_idx;
    logic [DIM_W-1:0] k_last_idx;
    logic [DIM_W-1:0] n_last_idx;

    assign m_last_idx = eff_dim(rows_a_reg) - 4'd1;
    assign k_last_idx = eff_dim(inner_dim_reg) - 4'd1;
    assign n_last_idx = eff_dim(cols_b_reg) - 4'd1;

    // Sequencer state and loop counters.
    state_t           state_reg, state_next;
    logic [IDX_W-1:0] i_reg, i_next;
    logic [IDX_W-1:0] j_reg, j_next;
    logic [IDX_W-1:0] k_reg, k_next;
    logic             issue;
    logic             i_at_last, j_at_last, k_at_last;
    logic             pipe_idle;

    // Pipeline control.
    logic rd_valid_reg, rd_last_reg;
    logic prod_valid_reg, prod_last_reg;
    logic out_valid_reg;

    assign i_at_last = (DIM_W'(i_reg) == m_last_idx);
    assign j_at_last = (DIM_W'(j_reg) == n_last_idx);
    assign k_at_last = (DIM_W'(k_reg) == k_last_idx);
    assign pipe_idle = !rd_valid_reg && !prod_valid_reg && !out_valid_reg;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        issue      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid && in_kind == KIND_COMPUTE)
                begin
                    i_next     = '0;
                    j_next     = '0;
                    k_next     = '0;
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE:
            begin
                // One product term of the current result per cycle.
                issue = 1'b1;
                if (k_at_last)
                begin
                    k_next     = '0;
                    state_next = ST_WAIT;
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end
            ST_WAIT:
            begin
                // Move on once the result has drained and been taken.
                if (pipe_idle)
                begin
                    if (i_at_last && j_at_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        if (j_at_last)
                        begin
                            j_next = '0;
                            i_next = i_reg + 1'b1;
                        end
                        else
                        begin
                            j_next = j_reg + 1'b1;
                        end
                        state_next = ST_ISSUE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
        end
    end

    // Operand stores, one write and one read port each.
    logic [ELEM_W-1:0]        mem_a [DEPTH];
    logic [ELEM_W-1:0]        mem_b [DEPTH];
    logic                     in_accept;
    logic                     load_in_range;
    logic                     load_a, load_b;
    logic [ADDR_W-1:0]        waddr;
    logic [ADDR_W-1:0]        a_raddr;
    logic [ADDR_W-1:0]        b_raddr;
    logic signed [ELEM_W-1:0] a_rd_reg;
    logic signed [ELEM_W-1:0] b_rd_reg;

    assign in_accept     = s_tvalid && s_tready;
    assign load_in_range = (32'(in_row) < MAX_DIM) && (32'(in_col) < MAX_DIM);
    assign load_a        = in_accept && in_kind == KIND_LOAD_A && load_in_range;
    assign load_b        = in_accept && in_kind == KIND_LOAD_B && load_in_range;
    assign waddr         = ADDR_W'(MAX_DIM * 32'(in_row) + 32'(in_col));
    assign a_raddr       = ADDR_W'(MAX_DIM * 32'(i_reg) + 32'(k_reg));
    assign b_raddr       = ADDR_W'(MAX_DIM * 32'(k_reg) + 32'(j_reg));

    always_ff @(posedge clk)
    begin
        if (load_a)
        begin
            mem_a[waddr] <= in_value;
        end
        if (load_b)
        begin
            mem_b[waddr] <= in_value;
        end
        a_rd_reg <= mem_a[a_raddr];
        b_rd_reg <= mem_b[b_raddr];
    end

    // Shared multiply-accumulate.
    logic signed [RES_W-1:0] prod_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_next;
    logic [ACC_W-RES_W:0]    acc_upper;
    logic                    clip;
    logic [RES_W-1:0]        clipped_value;
    logic                    finish;

    always_ff @(posedge clk)
    begin
        prod_reg <= a_rd_reg * b_rd_reg;
    end

    assign acc_next = acc_reg + ACC_W'(prod_reg);
    assign finish   = prod_valid_reg && prod_last_reg;

    // The sum fits in 32 bits when every bit above bit 30 matches the sign.
    assign acc_upper     = acc_next[ACC_W-1:RES_W-1];
    assign clip          = !(&acc_upper) && (|acc_upper);
    assign clipped_value = clip ? (acc_next[ACC_W-1] ? RES_MIN : RES_MAX)
                                : acc_next[RES_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg   <= 1'b0;
            rd_last_reg    <= 1'b0;
            prod_valid_reg <= 1'b0;
            prod_last_reg  <= 1'b0;
            acc_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            rd_valid_reg   <= issue;
            rd_last_reg    <= issue && k_at_last;
            prod_valid_reg <= rd_valid_reg;
            prod_last_reg  <= rd_last_reg;
            if (prod_valid_reg)
            begin
                acc_reg <= prod_last_reg ? '0 : acc_next;
            end
            if (finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Output register; the sequencer holds i and j until the result leaves.
    logic [IDX_FIELD_W-1:0] out_row_reg;
    logic [IDX_FIELD_W-1:0] out_col_reg;
    logic [RES_W-1:0]       out_value_reg;
    logic                   saturated_reg;
    logic                   last_reg;

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            out_row_reg   <= IDX_FIELD_W'(i_reg);
            out_col_reg   <= IDX_FIELD_W'(j_reg);
            out_value_reg <= clipped_value;
            saturated_reg <= clip;
            last_reg      <= i_at_last && j_at_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_value_reg, out_col_reg, out_row_reg};
    assign m_tuser  = saturated_reg;
    assign m_tlast  = last_reg;

endmodule

>>> tb/sv/testbench.sv
// Self-checking testbench for the matrix multiply engine. Loads operands,
// runs compute requests under random stream idling and predicts every result.
// Depends on mme_pkg and matrix_multiply_engine.
`timescale 1ns / 1ps

module testbench;
    import mme_pkg::*;

    localparam int          MAX_DIM      = 8;
    localparam int unsigned CYCLE_LIMIT  = 5000000;
    localparam int          IDLE_SETTLE  = 20;
    localparam longint      SUM_MAX      = 64'sd2147483647;
    localparam longint      SUM_MIN      = -64'sd2147483648;

    // One element of W as the block should emit it.
    typedef struct {
        logic [2:0]  row;
        logic [2:0]  col;
        logic [31:0] value;
        logic        sat;
        logic        last;
    } product_elem_t;

    // Keeps its own copy of both operand stores and the dimension registers,
    // computes W on every accepted compute request and checks the results
    // in order.
    class gemm_checker;
        logic [15:0]   a_mem [64];
        logic [15:0]   b_mem [64];
        logic [3:0]    dims [3];
        product_elem_t owed_elems [$];
        int unsigned   errors;

        function new();
            dims = '{DIM_RESET, DIM_RESET, DIM_RESET};
            errors = 0;
            foreach (a_mem[i]) a_mem[i] = '0;
            foreach (b_mem[i]) b_mem[i] = '0;
        endfunction

        // Zero counts as one and anything above MAX_DIM counts as MAX_DIM.
        function int eff_dim(int idx);
            if (dims[idx] == 0)
                return 1;
            if (dims[idx] > MAX_DIM)
                return MAX_DIM;
            return int'(dims[idx]);
        endfunction

        function void set_dim(int idx, logic [31:0] val);
            dims[idx] = val[3:0];
        endfunction

        function void predict_product();
            int            m;
            int            kd;
            int            n;
            longint        acc;
            longint        ea;
            longint        eb;
            product_elem_t e;
            m  = eff_dim(REG_ROWS_A);
            kd = eff_dim(REG_INNER_DIM);
            n  = eff_dim(REG_COLS_B);
            for (int i = 0; i < m; i++)
            begin
                for (int j = 0; j < n; j++)
                begin
                    acc = 0;
                    for (int k = 0; k < kd; k++)
                    begin
                        ea = $signed(a_mem[i * MAX_DIM + k]);
                        eb = $signed(b_mem[k * MAX_DIM + j]);
                        acc += ea * eb;
                    end
                    e.sat = 1'b0;
                    if (acc > SUM_MAX)
                    begin
                        acc = SUM_MAX;
                        e.sat = 1'b1;
                    end
                    else if (acc < SUM_MIN)
                    begin
                        acc = SUM_MIN;
                        e.sat = 1'b1;
                    end
                    e.row   = i[2:0];
                    e.col   = j[2:0];
                    e.value = acc[31:0];
                    e.last  = (i == m - 1) && (j == n - 1);
                    owed_elems.push_back(e);
                end
            end
        endfunction

        function void note_request(logic [1:0] kind, logic [2:0] row, logic [2:0] col,
                                   logic [15:0] value);
            case (kind)
                KIND_LOAD_A:  a_mem[{row, col}] = value;
                KIND_LOAD_B:  b_mem[{row, col}] = value;
                KIND_COMPUTE: predict_product();
                default: ;
            endcase
        endfunction

        function void check_result(logic [2:0] row, logic [2:0] col, logic [31:0] value,
                                   logic sat, logic last);
            product_elem_t e;
            if (owed_elems.size() == 0)
            begin
                $display("%0t: unexpected result row %0d col %0d value %h sat %b last %b",
                         $time, row, col, value, sat, last);
                errors++;
                return;
            end
            e = owed_elems.pop_front();
            if ({row, col, value, sat, last} !== {e.row, e.col, e.value, e.sat, e.last})
            begin
                $display("%0t: mismatch expected row %0d col %0d value %h sat %b last %b",
                         $time, e.row, e.col, e.value, e.sat, e.last);
                $display("%0t:          actual   row %0d col %0d value %h sat %b last %b",
                         $time, row, col, value, sat, last);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;   // row[2:0], col[5:3], value[21:6], zero fill
    logic [1:0]  s_tuser;   // kind[1:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;   // out_row[2:0], out_col[5:3], out_value[37:6], zero fill
    logic [0:0]  m_tuser;   // saturated[0]
    logic        m_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    gemm_checker board;

    // Which operand elements have been loaded; a compute is only sent once
    // every element it reads is marked here.
    bit          a_loaded [64];
    bit          b_loaded [64];
    int          burst_left;
    int          value_mode;
    int unsigned cycle_count;

    matrix_multiply_engine #(.MAX_DIM(MAX_DIM)) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Every accepted result is checked against the oldest expected element.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            board.check_result(m_tdata[2:0], m_tdata[5:3], m_tdata[37:6], m_tuser[0],
                               m_tlast);
    end

    // The sink stalls on a pattern of its own: stretches of steady ready,
    // coin-flip ready, and long stalls broken by short ready windows.
    initial
    begin
        int mode;
        int span;
        forever
        begin
            mode = $urandom_range(0, 2);
            span = $urandom_range(10, 60);
            for (int c = 0; c < span; c++)
            begin
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= 1'($urandom_range(0, 1));
                    default: m_tready <= ($urandom_range(0, 11) == 0);
                endcase
                @(posedge clk);
            end
        end
    end

    // Hard stop in case the block hangs.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Test completed with failures");
        $finish;
    end

    // Presents one request and holds it until accepted, then possibly
    // leaves a gap. Bursts have random length; gaps come between bursts.
    task automatic send_request(logic [1:0] kind, logic [2:0] row, logic [2:0] col,
                                logic [15:0] value);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {2'b00, value, col, row};
        do @(posedge clk); while (!s_tready);
        board.note_request(kind, row, col, value);
        if (kind == KIND_LOAD_A)
            a_loaded[{row, col}] = 1'b1;
        if (kind == KIND_LOAD_B)
            b_loaded[{row, col}] = 1'b1;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        else
            burst_left--;
    endtask

    // Sender pauses until every expected result is back, then lets the
    // block settle so a register write finds it idle.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (board.owed_elems.size() != 0)
            @(posedge clk);
        repeat (IDLE_SETTLE) @(posedge clk);
    endtask

    // Setup cycle, then access cycle; the register takes the write at the
    // edge where the access cycle completes.
    task automatic apb_write(logic [1:0] idx, logic [3:0] val);
        logic [31:0] upper;
        upper = $urandom;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {upper[31:4], val};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        board.set_dim(idx, {upper[31:4], val});
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_dims(logic [3:0] r, logic [3:0] k, logic [3:0] c);
        apb_write(REG_ROWS_A, r);
        apb_write(REG_INNER_DIM, k);
        apb_write(REG_COLS_B, c);
    endtask

    // Operand values shaped by the phase: full random, small, large with
    // matching signs (positive clipping), large with opposite signs
    // (negative clipping), or a mix of the extremes.
    function automatic logic [15:0] rand_value(bit for_b);
        logic [15:0] r;
        r = 16'($urandom_range(0, 15));
        case (value_mode)
            0: return 16'($urandom);
            1: return 16'($urandom_range(0, 511)) - 16'd256;
            2: return 16'h8000 | r;
            3: return for_b ? (16'h7FFF - r) : (16'h8000 | r);
            default:
            begin
                case ($urandom_range(0, 4))
                    0: return 16'h8000;
                    1: return 16'h7FFF;
                    2: return 16'h0000;
                    3: return 16'hFFFF;
                    default: return 16'h0001;
                endcase
            end
        endcase
    endfunction

    // Loads every operand element the next compute will read that has not
    // been written yet, and reports how many loads that took.
    task automatic fill_missing(output int sent);
        int m;
        int kd;
        int n;
        sent = 0;
        m  = board.eff_dim(REG_ROWS_A);
        kd = board.eff_dim(REG_INNER_DIM);
        n  = board.eff_dim(REG_COLS_B);
        for (int i = 0; i < m; i++)
            for (int k = 0; k < kd; k++)
                if (!a_loaded[i * MAX_DIM + k])
                begin
                    send_request(KIND_LOAD_A, i[2:0], k[2:0], rand_value(1'b0));
                    sent++;
                end
        for (int k = 0; k < kd; k++)
            for (int j = 0; j < n; j++)
                if (!b_loaded[k * MAX_DIM + j])
                begin
                    send_request(KIND_LOAD_B, k[2:0], j[2:0], rand_value(1'b1));
                    sent++;
                end
    endtask

    // Mostly loads inside the active window followed by computes, with
    // some loads anywhere and some unused-kind noise mixed in.
    task automatic run_phase(int items);
        int done;
        int pick;
        int m;
        int kd;
        int n;
        int filled;
        done = 0;
        m  = board.eff_dim(REG_ROWS_A);
        kd = board.eff_dim(REG_INNER_DIM);
        n  = board.eff_dim(REG_COLS_B);
        while (done < items)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 38)
                send_request(KIND_LOAD_A, 3'($urandom_range(0, m - 1)),
                             3'($urandom_range(0, kd - 1)), rand_value(1'b0));
            else if (pick < 76)
                send_request(KIND_LOAD_B, 3'($urandom_range(0, kd - 1)),
                             3'($urandom_range(0, n - 1)), rand_value(1'b1));
            else if (pick < 84)
                send_request(2'($urandom_range(0, 1)), 3'($urandom), 3'($urandom),
                             16'($urandom));
            else if (pick < 88)
            begin
                // Unused kind: dropped by the block, not counted.
                send_request(2'b11, 3'($urandom), 3'($urandom), 16'($urandom));
                done--;
            end
            else
            begin
                fill_missing(filled);
                done += filled;
                send_request(KIND_COMPUTE, 3'($urandom), 3'($urandom), 16'($urandom));
            end
            done++;
        end
    endtask

    initial
    begin
        logic [3:0] ph_rows  [7];
        logic [3:0] ph_inner [7];
        logic [3:0] ph_cols  [7];
        int         ph_mode  [7];
        board = new();
        burst_left = 0;
        value_mode = 0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= '0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        rst_n    <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: one row by one column over three products.
        set_dims(4'd1, 4'd3, 4'd1);
        // Most negative operands everywhere: the sum clips high.
        for (int k = 0; k < 3; k++)
            send_request(KIND_LOAD_A, 3'd0, k[2:0], 16'h8000);
        for (int k = 0; k < 3; k++)
            send_request(KIND_LOAD_B, k[2:0], 3'd0, 16'h8000);
        send_request(KIND_COMPUTE, 3'd7, 3'd7, 16'hFFFF);
        // Most positive B against most negative A: the sum clips low.
        for (int k = 0; k < 3; k++)
            send_request(KIND_LOAD_B, k[2:0], 3'd0, 16'h7FFF);
        // Unused kind with every field at its top is dropped.
        send_request(2'b11, 3'd7, 3'd7, 16'hFFFF);
        send_request(KIND_COMPUTE, 3'd0, 3'd0, 16'h0000);
        // Far corner of both stores, then a mixed sum that stays in range.
        send_request(KIND_LOAD_A, 3'd7, 3'd7, 16'h7FFF);
        send_request(KIND_LOAD_B, 3'd7, 3'd7, 16'h0001);
        send_request(KIND_LOAD_A, 3'd0, 3'd0, 16'h0000);
        send_request(KIND_LOAD_A, 3'd0, 3'd1, 16'h0001);
        send_request(KIND_LOAD_B, 3'd1, 3'd0, 16'hFFFF);
        send_request(KIND_COMPUTE, 3'd5, 3'd2, 16'h5A5A);
        wait_idle();

        // Random part: the extremes of every register first, zero and
        // above-range values among them, then random settings.
        ph_rows  = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd2, 4'($urandom), 4'($urandom)};
        ph_inner = '{4'd1, 4'd8, 4'd15, 4'd0, 4'd8, 4'($urandom), 4'($urandom)};
        ph_cols  = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd3, 4'($urandom), 4'($urandom)};
        ph_mode  = '{0, 2, 4, 3, 1, $urandom_range(0, 4), $urandom_range(0, 4)};
        for (int p = 0; p < 7; p++)
        begin
            set_dims(ph_rows[p], ph_inner[p], ph_cols[p]);
            value_mode = ph_mode[p];
            run_phase(60);
            wait_idle();
        end

        if (board.errors == 0 && board.owed_elems.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

>>> matrix_multiply_engine.f
src/mme_pkg.sv
src/matrix_multiply_engine.sv
tb/sv/testbench.sv
